FILE: src/wtri_pkg.sv
package wtri_pkg;

  localparam int COORD_W   = 24;
  localparam int PAD_W     = COORD_W - 1;
  localparam int SIDE_W    = COORD_W + 2;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int NRM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W - 1;
  localparam int LO_W      = EDGE_W;
  localparam int HI_W      = MAG_W - LO_W;
  localparam int HH_W      = 2 * HI_W;
  localparam int HL_W      = HI_W + LO_W;
  localparam int LL_W      = 2 * LO_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int COS_W     = 16;
  localparam int C2_W      = 31;
  localparam int CHUNK_W   = SUM_W / 4;
  localparam int PP_W      = CHUNK_W + C2_W;
  localparam int RHS_W     = SUM_W + C2_W;
  localparam int SLOPE_SH  = 30;
  localparam int NSTAGE    = 10;

  localparam int IN_DATA_W  = 9 * COORD_W;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_W;

  localparam logic [COS_W-1:0] COS_ONE   = 16'd32768;
  localparam logic [COS_W-1:0] COS_RESET = 16'd23170;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SIDE_W-1:0]  side_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [NRM_W-1:0]   nrm_t;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_BOUNDS   = 3'd1,
    VERDICT_DEGEN    = 3'd2,
    VERDICT_SLOPE    = 3'd3,
    VERDICT_TILE_BAD = 3'd4
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5,
    REG_PAD   = 3'd6,
    REG_COS   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic hit;
    logic walk;
    logic zero;
  } flags_t;

endpackage

FILE: src/walkable_triangle_filter_unit.sv
// pipeline: each item reaches its verdict in the output register through ten
// register stages, counting the one that takes the item
// throughput: one triangle per cycle unless m_tready stalls the ten-stage multiply and compare pipeline
// each stage advances when empty or when the stage after it moves, so bubbles collapse
// reset: synchronous; clears all stage valid bits and loads the tile box to the full
// coordinate range, padding 0 and the slope cosine to about cos 45 degrees
module walkable_triangle_filter_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [wtri_pkg::IN_DATA_W-1:0]     s_tdata,
  // walkable
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // verdict, zero fill
  output logic [wtri_pkg::OUT_DATA_W-1:0]    m_tdata,
  // accepted
  output logic                               m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wtri_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wtri_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wtri_pkg::*;

  // configuration
  coord_t           tile_min [3];
  coord_t           tile_max [3];
  logic [PAD_W-1:0] tile_pad;
  logic [COS_W-1:0] cos_max_slope;
  logic [COS_W-1:0] cos_next;

  side_t            box_lo [3];
  side_t            box_hi [3];
  logic             tile_bad;
  logic [C2_W-1:0]  cos_sq;

  // handshake
  logic             vld [1:NSTAGE];
  logic             en  [1:NSTAGE];

  coord_t           vert [3][3];

  // stage registers
  edge_t            s1_u [3];
  edge_t            s1_v [3];
  coord_t           s1_mn [3];
  coord_t           s1_mx [3];
  logic             s1_walk;

  prod_t            s2_p [6];
  flags_t           s2_f;

  nrm_t             s3_n [3];
  flags_t           s3_f;

  logic [MAG_W-1:0] s4_m [3];
  flags_t           s4_f;

  logic [HH_W-1:0]  s5_hh [3];
  logic [HL_W-1:0]  s5_hl [3];
  logic [LL_W-1:0]  s5_ll [3];
  flags_t           s5_f;

  logic [SQ_W-1:0]  s6_sq [3];
  flags_t           s6_f;

  logic [SUM_W-1:0] s7_sum;
  logic [SQ_W-1:0]  s7_lhs;
  flags_t           s7_f;

  logic [PP_W-1:0]  s8_pp [4];
  logic [SQ_W-1:0]  s8_lhs;
  flags_t           s8_f;

  logic [RHS_W-1:0] s9_rhs;
  logic [SQ_W-1:0]  s9_lhs;
  flags_t           s9_f;

  verdict_t         out_verdict;
  verdict_t         verdict_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cos_next = cfg_data[COS_W-1:0];
    if (cos_next > COS_ONE) begin
      cos_next = COS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        tile_min[k] <= {1'b1, {(COORD_W-1){1'b0}}};
        tile_max[k] <= {1'b0, {(COORD_W-1){1'b1}}};
      end
      tile_pad      <= '0;
      cos_max_slope <= COS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_X: tile_min[0] <= coord_t'(cfg_data);
        REG_MIN_Y: tile_min[1] <= coord_t'(cfg_data);
        REG_MIN_Z: tile_min[2] <= coord_t'(cfg_data);
        REG_MAX_X: tile_max[0] <= coord_t'(cfg_data);
        REG_MAX_Y: tile_max[1] <= coord_t'(cfg_data);
        REG_MAX_Z: tile_max[2] <= coord_t'(cfg_data);
        REG_PAD:   tile_pad    <= cfg_data[PAD_W-1:0];
        REG_COS:   cos_max_slope <= cos_next;
        default: ;
      endcase
    end
  end

  // padded box, tile check and cosine square are registered from the registers in the next cycle
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      box_lo[k] <= side_t'(tile_min[k]) - $signed(SIDE_W'(tile_pad));
      box_hi[k] <= side_t'(tile_max[k]) + $signed(SIDE_W'(tile_pad));
    end
    tile_bad <= (tile_min[0] > tile_max[0]) || (tile_min[1] > tile_max[1]) ||
                (tile_min[2] > tile_max[2]);
    cos_sq   <= C2_W'(32'(cos_max_slope) * 32'(cos_max_slope));
  end

  always_comb begin
    en[NSTAGE] = !vld[NSTAGE] || m_tready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTAGE; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      if (en[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        vert[v][k] = coord_t'(s_tdata[COORD_W*(3*v+k) +: COORD_W]);
      end
    end
  end

  // stage 1: edges and per-axis extent
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s1_u[k]  <= edge_t'(vert[1][k]) - edge_t'(vert[0][k]);
        s1_v[k]  <= edge_t'(vert[2][k]) - edge_t'(vert[0][k]);
        s1_mn[k] <= (vert[0][k] < vert[1][k]) ?
                    ((vert[0][k] < vert[2][k]) ? vert[0][k] : vert[2][k]) :
                    ((vert[1][k] < vert[2][k]) ? vert[1][k] : vert[2][k]);
        s1_mx[k] <= (vert[0][k] > vert[1][k]) ?
                    ((vert[0][k] > vert[2][k]) ? vert[0][k] : vert[2][k]) :
                    ((vert[1][k] > vert[2][k]) ? vert[1][k] : vert[2][k]);
      end
      s1_walk <= s_tuser;
    end
  end

  // stage 2: cross product terms and box overlap
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_p[0] <= s1_u[1] * s1_v[2];
      s2_p[1] <= s1_u[2] * s1_v[1];
      s2_p[2] <= s1_u[2] * s1_v[0];
      s2_p[3] <= s1_u[0] * s1_v[2];
      s2_p[4] <= s1_u[0] * s1_v[1];
      s2_p[5] <= s1_u[1] * s1_v[0];
      s2_f.hit <= (side_t'(s1_mn[0]) <= box_hi[0]) && (side_t'(s1_mx[0]) >= box_lo[0]) &&
                  (side_t'(s1_mn[1]) <= box_hi[1]) && (side_t'(s1_mx[1]) >= box_lo[1]) &&
                  (side_t'(s1_mn[2]) <= box_hi[2]) && (side_t'(s1_mx[2]) >= box_lo[2]);
      s2_f.walk <= s1_walk;
      s2_f.zero <= 1'b0;
    end
  end

  // stage 3: normal
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        s3_n[k] <= nrm_t'(s2_p[2*k]) - nrm_t'(s2_p[2*k+1]);
      end
      s3_f <= s2_f;
    end
  end

  // stage 4: magnitudes, zero normal
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        s4_m[k] <= MAG_W'((s3_n[k] < 0) ? -s3_n[k] : s3_n[k]);
      end
      s4_f.hit  <= s3_f.hit;
      s4_f.walk <= s3_f.walk;
      s4_f.zero <= (s3_n[0] == '0) && (s3_n[1] == '0) && (s3_n[2] == '0);
    end
  end

  // stage 5: square partial products
  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        s5_hh[k] <= HH_W'(s4_m[k][MAG_W-1:LO_W] * s4_m[k][MAG_W-1:LO_W]);
        s5_hl[k] <= HL_W'(s4_m[k][MAG_W-1:LO_W] * s4_m[k][LO_W-1:0]);
        s5_ll[k] <= LL_W'(s4_m[k][LO_W-1:0] * s4_m[k][LO_W-1:0]);
      end
      s5_f <= s4_f;
    end
  end

  // stage 6: squares
  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int k = 0; k < 3; k++) begin
        s6_sq[k] <= (SQ_W'(s5_hh[k]) << (2 * LO_W)) + (SQ_W'(s5_hl[k]) << (LO_W + 1)) +
                    SQ_W'(s5_ll[k]);
      end
      s6_f <= s5_f;
    end
  end

  // stage 7: squared length
  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_sum <= SUM_W'(s6_sq[0]) + SUM_W'(s6_sq[1]) + SUM_W'(s6_sq[2]);
      s7_lhs <= s6_sq[1];
      s7_f   <= s6_f;
    end
  end

  // stage 8: length times cosine square, in chunks
  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int i = 0; i < 4; i++) begin
        s8_pp[i] <= PP_W'(s7_sum[CHUNK_W*i +: CHUNK_W] * cos_sq);
      end
      s8_lhs <= s7_lhs;
      s8_f   <= s7_f;
    end
  end

  // stage 9: chunk sum
  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_rhs <= RHS_W'(s8_pp[0]) + (RHS_W'(s8_pp[1]) << CHUNK_W) +
                (RHS_W'(s8_pp[2]) << (2 * CHUNK_W)) + (RHS_W'(s8_pp[3]) << (3 * CHUNK_W));
      s9_lhs <= s8_lhs;
      s9_f   <= s8_f;
    end
  end

  // stage 10: slope compare and verdict
  always_comb begin
    if (tile_bad) begin
      verdict_next = VERDICT_TILE_BAD;
    end else if (!s9_f.hit) begin
      verdict_next = VERDICT_BOUNDS;
    end else if (!s9_f.walk) begin
      verdict_next = VERDICT_OK;
    end else if (s9_f.zero) begin
      verdict_next = VERDICT_DEGEN;
    end else if ((RHS_W'(s9_lhs) << SLOPE_SH) >= s9_rhs) begin
      verdict_next = VERDICT_OK;
    end else begin
      verdict_next = VERDICT_SLOPE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTAGE]) begin
      out_verdict <= verdict_next;
    end
  end

  assign m_tvalid = vld[NSTAGE];
  assign m_tdata  = {{(OUT_DATA_W-3){1'b0}}, out_verdict};
  assign m_tuser  = (out_verdict == VERDICT_OK);

endmodule

FILE: test/tb_walkable_triangle_filter_unit.sv
`timescale 1ns / 100ps

module tb_walkable_triangle_filter_unit;
  import wtri_pkg::*;

  localparam longint COORD_LO = -longint'(2 ** (COORD_W - 1));
  localparam longint COORD_HI = longint'(2 ** (COORD_W - 1)) - 1;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    logic     accepted;
    verdict_t verdict;
  } verdict_item_t;

  class verdict_board;
    verdict_item_t pending[$];
    int errors;
    int tally[5];

    function void note(verdict_item_t e);
      pending.insert(pending.size(), e);
      tally[e.verdict]++;
    endfunction

    function void check(logic acc, logic [2:0] vd);
      verdict_item_t e;
      if (pending.size() == 0) begin
        errors++;
        $error("unexpected item: accepted %0d verdict %0d", acc, vd);
        return;
      end
      e = pending.pop_front();
      if (acc !== e.accepted) begin
        errors++;
        $error("accepted: expected %0d, actual %0d", e.accepted, acc);
      end
      if (vd !== e.verdict) begin
        errors++;
        $error("verdict: expected %0d, actual %0d", e.verdict, vd);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_MIN_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  walkable_triangle_filter_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  verdict_board board;

  // copy of the register file
  longint box_lo[3];
  longint box_hi[3];
  longint box_pad;
  int unsigned cos_lim;

  longint pt[9];
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit drain_next = 1'b0;
  int settings = 0;
  int items_sent = 0;
  int hold = 0;
  int idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint clamp_coord(longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic longint pick(longint a, longint b);
    longint unsigned span;
    longint unsigned r;
    if (b <= a) return a;
    span = longint'(b - a) + 1;
    r = {$urandom, $urandom};
    return a + longint'(r % span);
  endfunction

  function automatic logic [191:0] mag_of(longint v);
    return (v < 0) ? 192'(-v) : 192'(v);
  endfunction

  function automatic verdict_t judge_triangle(logic [IN_DATA_W-1:0] d, logic walk);
    longint p[9];
    longint mn, mx, ux, uy, uz, vx, vy, vz, nx, ny, nz;
    logic [191:0] sx, sy, sz, lhs, rhs;
    for (int i = 0; i < 9; i++) p[i] = longint'($signed(d[i*COORD_W +: COORD_W]));
    for (int a = 0; a < 3; a++)
      if (box_lo[a] > box_hi[a]) return VERDICT_TILE_BAD;
    for (int a = 0; a < 3; a++) begin
      mn = p[a];
      mx = p[a];
      for (int v = 1; v < 3; v++) begin
        if (p[v*3+a] < mn) mn = p[v*3+a];
        if (p[v*3+a] > mx) mx = p[v*3+a];
      end
      if (mn > box_hi[a] + box_pad || mx < box_lo[a] - box_pad) return VERDICT_BOUNDS;
    end
    if (!walk) return VERDICT_OK;
    ux = p[3] - p[0];
    uy = p[4] - p[1];
    uz = p[5] - p[2];
    vx = p[6] - p[0];
    vy = p[7] - p[1];
    vz = p[8] - p[2];
    nx = uy * vz - uz * vy;
    ny = uz * vx - ux * vz;
    nz = ux * vy - uy * vx;
    if (nx == 0 && ny == 0 && nz == 0) return VERDICT_DEGEN;
    sx = mag_of(nx);
    sy = mag_of(ny);
    sz = mag_of(nz);
    lhs = (sy * sy) << SLOPE_SH;
    rhs = (sx * sx + sy * sy + sz * sz) * 192'(cos_lim * cos_lim);
    return (lhs >= rhs) ? VERDICT_OK : VERDICT_SLOPE;
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_X: box_lo[0] = longint'($signed(val));
      REG_MIN_Y: box_lo[1] = longint'($signed(val));
      REG_MIN_Z: box_lo[2] = longint'($signed(val));
      REG_MAX_X: box_hi[0] = longint'($signed(val));
      REG_MAX_Y: box_hi[1] = longint'($signed(val));
      REG_MAX_Z: box_hi[2] = longint'($signed(val));
      REG_PAD: box_pad = longint'(val[PAD_W-1:0]);
      REG_COS: begin
        cos_lim = val[COS_W-1:0];
        if (cos_lim > COS_ONE) cos_lim = COS_ONE;
      end
      default: ;
    endcase
  endtask

  task automatic apply_setting(longint lx, longint ly, longint lz, longint hx, longint hy,
                               longint hz, logic [CFG_DATA_W-1:0] pad_raw,
                               logic [CFG_DATA_W-1:0] cos_raw);
    wait_drained();
    write_reg(REG_MIN_X, coord_t'(lx));
    write_reg(REG_MIN_Y, coord_t'(ly));
    write_reg(REG_MIN_Z, coord_t'(lz));
    write_reg(REG_MAX_X, coord_t'(hx));
    write_reg(REG_MAX_Y, coord_t'(hy));
    write_reg(REG_MAX_Z, coord_t'(hz));
    write_reg(REG_PAD, pad_raw);
    write_reg(REG_COS, cos_raw);
    cfg_valid <= 1'b0;
    settings++;
    in_burst = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
  endtask

  // bad_axis < 0 keeps every axis valid
  task automatic random_setting(longint max_span, logic [CFG_DATA_W-1:0] pad_raw,
                                logic [CFG_DATA_W-1:0] cos_raw, int bad_axis);
    longint lo[3];
    longint hi[3];
    for (int a = 0; a < 3; a++) begin
      if (a == bad_axis) begin
        lo[a] = pick(COORD_LO + 1, COORD_HI);
        hi[a] = pick(COORD_LO, lo[a] - 1);
      end else begin
        lo[a] = pick(COORD_LO, COORD_HI - max_span);
        hi[a] = lo[a] + pick(0, max_span);
      end
    end
    apply_setting(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], pad_raw, cos_raw);
  endtask

  task automatic send_triangle(logic walk);
    int gap;
    logic [IN_DATA_W-1:0] d;
    verdict_item_t e;
    for (int i = 0; i < 9; i++) d[i*COORD_W +: COORD_W] = coord_t'(pt[i]);
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (drain_next || $urandom_range(0, 79) == 0) begin
      drain_next = 1'b0;
      if (gap == 0) gap = 1;
      s_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clk);
    end else if (gap > 0) begin
      s_tvalid <= 1'b0;
    end
    repeat (gap) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= walk;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    e.verdict = judge_triangle(d, walk);
    e.accepted = (e.verdict == VERDICT_OK);
    board.note(e);
    items_sent++;
  endtask

  task automatic place(longint ax, longint ay, longint az, longint bx, longint by,
                       longint bz, longint cx, longint cy, longint cz, logic walk);
    pt = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    send_triangle(walk);
  endtask

  task automatic shape_random();
    int kind;
    int a;
    longint ctr[3];
    longint span[3];
    longint mn, mx, shift, step, k;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      for (int i = 0; i < 9; i++) pt[i] = pick(COORD_LO, COORD_HI);
      return;
    end
    for (int j = 0; j < 3; j++) begin
      ctr[j] = pick(clamp_coord(box_lo[j] - box_pad), clamp_coord(box_hi[j] + box_pad));
      span[j] = ($urandom_range(0, 5) == 0) ? 0 : (longint'(1) << $urandom_range(0, 20));
    end
    for (int v = 0; v < 3; v++)
      for (int j = 0; j < 3; j++)
        pt[v*3+j] = clamp_coord(ctr[j] + pick(-span[j], span[j]));
    if (kind < 30) begin
      // push one axis to just touch or just miss the padded box
      a = $urandom_range(0, 2);
      mn = pt[a];
      mx = pt[a];
      for (int v = 1; v < 3; v++) begin
        if (pt[v*3+a] < mn) mn = pt[v*3+a];
        if (pt[v*3+a] > mx) mx = pt[v*3+a];
      end
      if ($urandom_range(0, 1))
        shift = box_lo[a] - box_pad - mx - $urandom_range(0, 1);
      else
        shift = box_hi[a] + box_pad - mn + $urandom_range(0, 1);
      for (int v = 0; v < 3; v++) pt[v*3+a] = clamp_coord(pt[v*3+a] + shift);
    end else if (kind < 40) begin
      // collinear vertices
      k = pick(-3, 3);
      for (int j = 0; j < 3; j++) begin
        step = pick(-4096, 4096);
        pt[3+j] = clamp_coord(pt[j] + step);
        pt[6+j] = clamp_coord(pt[j] + k * step);
      end
    end
  endtask

  task automatic run_random(int n);
    repeat (n) begin
      shape_random();
      send_triangle($urandom_range(0, 4) != 0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check(m_tuser, m_tdata[2:0]);
      hold = out_burst ? 0 : $urandom_range(0, 10);
    end else if (hold > 0) begin
      hold--;
    end
    m_tready <= (hold == 0);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("walkable_triangle_filter_unit verification failed");
      $finish;
    end
  end

  initial begin
    board = new();
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = COORD_LO;
      box_hi[a] = COORD_HI;
    end
    box_pad = 0;
    cos_lim = COS_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: coordinate extremes and the 45 degree boundary
    place(COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO, COORD_LO,
          COORD_LO, COORD_LO, COORD_LO, 1'b1);
    place(COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI, COORD_HI,
          COORD_HI, COORD_HI, COORD_HI, 1'b0);
    place(COORD_LO, 0, COORD_LO, COORD_HI, 0, COORD_LO, COORD_LO, 0, COORD_HI, 1'b1);
    place(COORD_LO, COORD_LO, 0, COORD_HI, COORD_LO, 0, COORD_LO, COORD_HI, 0, 1'b1);
    place(0, 0, 0, 256, 0, 0, 0, 256, 256, 1'b1);
    place(0, 0, 0, 256, 0, 0, 0, 257, 256, 1'b1);
    place(0, 0, 0, 256, 0, 0, 0, 257, 256, 1'b0);

    // small box, cosine one: touching faces, degenerate, blocker
    apply_setting(-1024, -1024, -1024, 1024, 1024, 1024, 256, 32768);
    place(-2000, 0, 0, -1280, 0, 0, -1500, 0, 100, 1'b1);
    place(-2001, 0, 0, -1281, 0, 0, -1501, 0, 100, 1'b1);
    place(0, 0, 1280, 100, 0, 1280, 0, 0, 1400, 1'b1);
    place(0, 1281, 0, 100, 1281, 0, 0, 1281, 100, 1'b1);
    place(0, 0, 0, 256, 1, 0, 0, 0, 256, 1'b1);
    place(10, 20, 30, 20, 40, 60, 30, 60, 90, 1'b1);
    place(10, 20, 30, 20, 40, 60, 30, 60, 90, 1'b0);

    // stray upper bits in pad and cosine, cosine above one clamps
    apply_setting(-1024, -1024, -1024, 1024, 1024, 1024, 24'h800100, 24'hA5FFFF);
    place(0, 0, 0, 100, 0, 0, 0, 0, 100, 1'b1);
    place(0, 0, 0, 256, 1, 0, 0, 0, 256, 1'b1);
    place(-2000, 0, 0, -1280, 0, 0, -1500, 0, 100, 1'b1);

    // cosine zero
    apply_setting(-1024, -1024, -1024, 1024, 1024, 1024, 0, 0);
    place(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b1);
    place(10, 20, 30, 20, 40, 60, 30, 60, 90, 1'b1);

    // inverted tile box on each axis
    apply_setting(100, -1024, -1024, 99, 1024, 1024, 0, COS_RESET);
    place(0, 0, 0, 100, 0, 0, 0, 0, 100, 1'b1);
    apply_setting(-1024, 100, -1024, 1024, 99, 1024, 0, COS_RESET);
    place(0, 0, 0, 100, 0, 0, 0, 0, 100, 1'b0);
    apply_setting(-1024, -1024, 100, 1024, 1024, 99, 0, COS_RESET);
    place(0, 0, 0, 100, 0, 0, 0, 0, 100, 1'b1);

    // single point box
    apply_setting(0, 0, 0, 0, 0, 0, 0, COS_RESET);
    place(-10, 0, -10, 10, 0, -10, 0, 0, 10, 1'b1);
    place(1, 0, 1, 10, 0, 1, 1, 0, 10, 1'b1);

    apply_setting(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI, 0, COS_RESET);
    run_random(45);
    drain_next = 1'b1;
    run_random(45);
    random_setting(8192, 24'($urandom_range(0, 2048)),
                   {8'($urandom), 16'($urandom_range(0, 32768))}, -1);
    run_random(90);
    random_setting(longint'($urandom_range(0, 1 << 20)), 24'h7FFFFF, 32768, -1);
    run_random(80);
    random_setting(longint'($urandom_range(0, 1 << 16)), 24'($urandom_range(0, 4096)),
                   {8'($urandom), 16'h0000}, -1);
    run_random(80);
    random_setting(0, 0, 24'($urandom_range(0, 32768)), -1);
    run_random(80);
    random_setting(longint'($urandom_range(0, 1 << 16)), 24'($urandom),
                   24'($urandom), $urandom_range(0, 2));
    run_random(40);
    random_setting(longint'($urandom_range(0, 1 << 18)), 24'($urandom_range(0, 1 << 12)),
                   {8'($urandom), 16'($urandom_range(32769, 65535))}, -1);
    run_random(80);
    apply_setting(COORD_LO, COORD_LO, COORD_LO, COORD_HI, COORD_HI, COORD_HI, 0,
                  {8'($urandom), 16'($urandom_range(0, 32768))});
    run_random(80);

    wait_drained();
    repeat (NSTAGE + 10) @(posedge clk);
    if (board.pending.size() != 0) begin
      board.errors++;
      $error("%0d verdicts never arrived", board.pending.size());
    end
    $display("%0d triangles under %0d register settings, sender and receiver stalls mixed in",
             items_sent, settings);
    $display("verdicts: ok %0d, bounds %0d, degenerate %0d, slope %0d, bad tile %0d",
             board.tally[VERDICT_OK], board.tally[VERDICT_BOUNDS], board.tally[VERDICT_DEGEN],
             board.tally[VERDICT_SLOPE], board.tally[VERDICT_TILE_BAD]);
    if (board.errors == 0) begin
      $display("walkable_triangle_filter_unit verification clean");
    end else begin
      $display("walkable_triangle_filter_unit verification failed");
    end
    $finish;
  end

endmodule
